// ===== hdl/sdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdeq_pkg
// Shared types and constants for the sorted double-ended queue.
// ----------------------------------------------------------------------------
package sdeq_pkg;

   // Storage geometry
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_WIDTH   = $clog2(CAPACITY);
   localparam int CNT_WIDTH   = $clog2(CAPACITY + 1);

   // Port field widths
   localparam int OPCODE_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int OCC_WIDTH    = 5;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_INSERT       = 2'd0,
      OP_REMOVE_MIN   = 2'd1,
      OP_REMOVE_MAX   = 2'd2,
      OP_REMOVE_VALUE = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_HOLD = 1'b1
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;    // execute the transfer on the request channel this cycle
   } cmd_type;

endpackage

// ===== hdl/sdeq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdeq_ctrl
// Handshake controller: accepts a request transfer and holds the result
// register valid until the response transfer completes.
// ----------------------------------------------------------------------------
module sdeq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdeq_pkg::cmd_type cmd
);

   sdeq_pkg::ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdeq_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and outputs
   always_comb begin
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         sdeq_pkg::CTRL_IDLE: begin
            cmd.exec = req_valid;
            if (req_valid) begin
               state_in = sdeq_pkg::CTRL_HOLD;
            end
         end
         sdeq_pkg::CTRL_HOLD: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            // result leaves; a new request may refill the register at once
            cmd.exec  = req_valid && !rsp_stall;
            if (!rsp_stall && !req_valid) begin
               state_in = sdeq_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = sdeq_pkg::CTRL_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/sdeq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdeq_dpath
// Row of sorted cells. Every cell compares against the operand in parallel
// and shifts up (insert) or down (removal of the minimum or by value).
// ----------------------------------------------------------------------------
module sdeq_dpath (
   input  logic                                       clock,
   input  logic                                       reset,
   input  sdeq_pkg::cmd_type                          cmd,
   input  logic [sdeq_pkg::OPCODE_WIDTH-1:0]          req_opcode,
   input  logic signed [sdeq_pkg::VALUE_WIDTH-1:0]    req_operand_value,
   output logic signed [sdeq_pkg::VALUE_WIDTH-1:0]    rsp_removed_value,
   output logic [sdeq_pkg::STATUS_WIDTH-1:0]          rsp_status,
   output logic [sdeq_pkg::OCC_WIDTH-1:0]             rsp_occupancy
);

   localparam int CAP = sdeq_pkg::CAPACITY;
   localparam int VW  = sdeq_pkg::VALUE_WIDTH;
   localparam int CW  = sdeq_pkg::CNT_WIDTH;
   localparam int IW  = sdeq_pkg::IDX_WIDTH;

   logic signed [VW-1:0] cell_ff [CAP];
   logic signed [VW-1:0] cell_in [CAP];
   logic [CW-1:0]        count_ff, count_in;

   logic signed [VW-1:0] removed_ff, removed_in;
   sdeq_pkg::status_type status_ff, status_in;

   logic [CAP-1:0]       occupied;
   logic [CAP-1:0]       below;      // cell holds a value less than the operand
   logic [CAP-1:0]       match;
   logic                 found;
   logic                 is_full;
   logic                 is_empty;
   logic [CW-1:0]        tail_pos;
   logic [IW-1:0]        tail_idx;
   sdeq_pkg::op_type     op;

   // Per-cell compare
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         occupied[i] = (CW'(i) < count_ff);
         below[i]    = occupied[i] && (cell_ff[i] < req_operand_value);
         match[i]    = occupied[i] && (cell_ff[i] == req_operand_value);
      end
   end

   assign found    = |match;
   assign is_full  = (count_ff == CW'(CAP));
   assign is_empty = (count_ff == '0);
   assign tail_pos = count_ff - CW'(1);
   assign tail_idx = tail_pos[IW-1:0];
   assign op       = sdeq_pkg::op_type'(req_opcode);

   // Next cell contents, count and result
   always_comb begin
      cell_in    = cell_ff;
      count_in   = count_ff;
      removed_in = '0;
      status_in  = sdeq_pkg::STAT_OK;
      case (op)
         sdeq_pkg::OP_INSERT: begin
            if (is_full) begin
               status_in = sdeq_pkg::STAT_FULL;
            end else begin
               // cells at or above the slot shift up, the slot takes the operand
               cell_in[0] = below[0] ? cell_ff[0] : req_operand_value;
               for (int i = 1; i < CAP; i++) begin
                  if (below[i]) begin
                     cell_in[i] = cell_ff[i];
                  end else if (below[i-1]) begin
                     cell_in[i] = req_operand_value;
                  end else begin
                     cell_in[i] = cell_ff[i-1];
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         sdeq_pkg::OP_REMOVE_MIN: begin
            if (is_empty) begin
               status_in = sdeq_pkg::STAT_MISS;
            end else begin
               removed_in = cell_ff[0];
               for (int i = 0; i < CAP - 1; i++) begin
                  cell_in[i] = cell_ff[i+1];
               end
               count_in = tail_pos;
            end
         end
         sdeq_pkg::OP_REMOVE_MAX: begin
            if (is_empty) begin
               status_in = sdeq_pkg::STAT_MISS;
            end else begin
               removed_in = cell_ff[tail_idx];
               count_in   = tail_pos;
            end
         end
         default: begin
            // remove given value: cells from the first match upward shift down
            if (!found) begin
               status_in = sdeq_pkg::STAT_MISS;
            end else begin
               removed_in = req_operand_value;
               for (int i = 0; i < CAP - 1; i++) begin
                  if (!below[i]) begin
                     cell_in[i] = cell_ff[i+1];
                  end
               end
               count_in = tail_pos;
            end
         end
      endcase
   end

   // Cell row and result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cell_ff    <= cell_in;
         removed_ff <= removed_in;
         status_ff  <= status_in;
      end
   end

   // Occupancy counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_occupancy     = sdeq_pkg::OCC_WIDTH'(count_ff);

endmodule

// ===== hdl/sorted_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_double_ended_queue
// Holds up to 16 signed values in ascending order; insert, remove minimum,
// remove maximum and remove by value, one result per request.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_stall  | opcode, operand_value
//  rsp     | out       | rsp_valid/rsp_stall  | removed_value, status, occupancy
//
//  All cells compare and shift in parallel at the accepting edge, and the
//  result is valid in the next cycle.
//  One request per cycle is sustained while the response side takes results.
//  req_stall follows rsp_stall only while a result is waiting.
//  Synchronous reset empties the queue; cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [sdeq_pkg::OPCODE_WIDTH-1:0]       req_opcode,
   input  logic signed [sdeq_pkg::VALUE_WIDTH-1:0] req_operand_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [sdeq_pkg::VALUE_WIDTH-1:0] rsp_removed_value,
   output logic [sdeq_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [sdeq_pkg::OCC_WIDTH-1:0]          rsp_occupancy
);

   sdeq_pkg::cmd_type cmd;

   // Handshake controller
   sdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Sorted cell row
   sdeq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_operand_value (req_operand_value),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

// ===== tb/sv/sorted_double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_tb
// Self-checking bench for the sorted double-ended queue. A behavioral model of
// the ascending store predicts removed value, status and occupancy for every
// accepted request. Directed cases cover empty and full stores, extreme and
// repeated values; random phases mix operations with idle cycles on both
// channels and a long response hold-off that backs the request side up.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_tb;

   typedef logic signed [sdeq_pkg::VALUE_WIDTH-1:0] sdeq_value_type;

   typedef struct {
      sdeq_value_type                     removed;
      sdeq_pkg::status_type               status;
      logic [sdeq_pkg::OCC_WIDTH-1:0]     occupancy;
   } sdeq_result_type;

   // Clock, reset and DUT ports
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [sdeq_pkg::OPCODE_WIDTH-1:0]    req_opcode = '0;
   sdeq_value_type                       req_operand_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   sdeq_value_type                       rsp_removed_value;
   logic [sdeq_pkg::STATUS_WIDTH-1:0]    rsp_status;
   logic [sdeq_pkg::OCC_WIDTH-1:0]       rsp_occupancy;

   // Model of the store contents, kept in ascending order
   sdeq_value_type             model_store[$];
   // Results predicted for accepted requests, oldest first
   sdeq_result_type            expected_results[$];

   int                         error_count = 0;
   int                         mismatch_count = 0;
   bit                         req_idle_on = 1'b1;
   bit                         rsp_idle_on = 1'b1;
   int                         rsp_hold_left = 0;

   sorted_double_ended_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run time limit
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Apply one operation to the model and queue the expected result
   function automatic void predict_queue_op(input sdeq_pkg::op_type op,
                                            input sdeq_value_type val);
      sdeq_result_type exp;
      int              pos;
      exp.removed = '0;
      exp.status  = sdeq_pkg::STAT_OK;
      if (op == sdeq_pkg::OP_INSERT) begin
         if (model_store.size() >= sdeq_pkg::CAPACITY) begin
            exp.status = sdeq_pkg::STAT_FULL;
         end else begin
            // equal values go in front of the stored ones
            pos = 0;
            while (pos < model_store.size() && model_store[pos] < val) pos++;
            model_store.insert(pos, val);
         end
      end else if (model_store.size() == 0) begin
         exp.status = sdeq_pkg::STAT_MISS;
      end else if (op == sdeq_pkg::OP_REMOVE_MIN) begin
         exp.removed = model_store.pop_front();
      end else if (op == sdeq_pkg::OP_REMOVE_MAX) begin
         exp.removed = model_store.pop_back();
      end else begin
         pos = -1;
         foreach (model_store[i]) begin
            if (pos < 0 && model_store[i] == val) pos = i;
         end
         if (pos < 0) begin
            exp.status = sdeq_pkg::STAT_MISS;
         end else begin
            exp.removed = model_store[pos];
            model_store.delete(pos);
         end
      end
      exp.occupancy = sdeq_pkg::OCC_WIDTH'(model_store.size());
      expected_results.push_back(exp);
   endfunction

   // Offer one request, hold it until the transfer, then predict
   task automatic send_op(input sdeq_pkg::op_type op, input sdeq_value_type val);
      @(negedge clock);
      while (req_idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_operand_value <= val;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_queue_op(op, val);
   endtask

   // Drop valid and wait until every predicted result has arrived
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic sdeq_value_type pick_operand(input bit wide);
      int sel;
      sel = $urandom_range(99);
      if (sel < 3) return sdeq_value_type'(32'h8000_0000);
      if (sel < 6) return sdeq_value_type'(32'h7FFF_FFFF);
      if (wide) return sdeq_value_type'($urandom);
      return sdeq_value_type'($signed($urandom_range(15)) - 8);
   endfunction

   // One random request; remove-by-value mostly targets a stored entry
   task automatic send_random(input int insert_pct, input bit wide);
      sdeq_pkg::op_type op;
      sdeq_value_type   val;
      if ($urandom_range(99) < insert_pct) op = sdeq_pkg::OP_INSERT;
      else op = sdeq_pkg::op_type'($urandom_range(3, 1));
      if (op == sdeq_pkg::OP_REMOVE_VALUE && model_store.size() > 0 &&
          $urandom_range(99) < 70)
         val = model_store[$urandom_range(model_store.size() - 1)];
      else
         val = pick_operand(wide);
      send_op(op, val);
   endtask

   // Response side: random stalls plus a counted long hold-off
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (rsp_idle_on && $urandom_range(99) < 16) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      sdeq_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result removed=%0d status=%0d occupancy=%0d",
                     $realtime, rsp_removed_value, rsp_status, rsp_occupancy);
         end else begin
            exp = expected_results.pop_front();
            if (rsp_removed_value !== exp.removed || rsp_status !== exp.status ||
                rsp_occupancy !== exp.occupancy) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch removed %0d/%0d status %0d/%0d occupancy %0d/%0d",
                           $realtime, exp.removed, rsp_removed_value, exp.status,
                           rsp_status, exp.occupancy, rsp_occupancy);
            end
         end
      end
   end

   // Removals of every kind on an empty store
   task automatic test_empty_store();
      send_op(sdeq_pkg::OP_REMOVE_MIN, '0);
      send_op(sdeq_pkg::OP_REMOVE_MAX, '0);
      send_op(sdeq_pkg::OP_REMOVE_VALUE, '0);
   endtask

   // Most negative and most positive values, hit and miss by value
   task automatic test_extreme_values();
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(32'h7FFF_FFFF));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(32'h8000_0000));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(0));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(-1));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(1));
      send_op(sdeq_pkg::OP_REMOVE_VALUE, sdeq_value_type'(-1));
      send_op(sdeq_pkg::OP_REMOVE_VALUE, sdeq_value_type'(12345));
      send_op(sdeq_pkg::OP_REMOVE_MIN, '0);
      send_op(sdeq_pkg::OP_REMOVE_MAX, '0);
      send_op(sdeq_pkg::OP_REMOVE_VALUE, sdeq_value_type'(0));
      send_op(sdeq_pkg::OP_REMOVE_MIN, '0);
   endtask

   // Repeated values, then a search on an emptied store
   task automatic test_equal_values();
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(7));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(7));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(-7));
      send_op(sdeq_pkg::OP_INSERT, sdeq_value_type'(7));
      send_op(sdeq_pkg::OP_REMOVE_VALUE, sdeq_value_type'(7));
      send_op(sdeq_pkg::OP_REMOVE_MAX, '0);
      send_op(sdeq_pkg::OP_REMOVE_MIN, '0);
      send_op(sdeq_pkg::OP_REMOVE_VALUE, sdeq_value_type'(7));
      send_op(sdeq_pkg::OP_REMOVE_VALUE, sdeq_value_type'(7));
   endtask

   // Long response hold-off while requests keep coming
   task automatic test_backpressure();
      @(posedge clock);
      rsp_hold_left = 100;
      repeat (40) send_random(60, 1'b0);
      wait_for_drain();
   endtask

   // Fill past capacity, then empty again
   task automatic test_full_store();
      repeat (3) begin
         while (model_store.size() < sdeq_pkg::CAPACITY) send_random(100, 1'b1);
         repeat (3) send_op(sdeq_pkg::OP_INSERT, pick_operand(1'b1));
         while (model_store.size() > 0) send_random(0, 1'b1);
         send_random(0, 1'b0);
      end
      wait_for_drain();
   endtask

   task automatic test_random_mix(input int count, input int insert_pct, input bit wide);
      repeat (count) send_random(insert_pct, wide);
      wait_for_drain();
   endtask

   // Both channels busy every cycle
   task automatic test_no_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (200) send_random(50, 1'($urandom_range(1)));
      wait_for_drain();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_extreme_values();
      test_equal_values();
      wait_for_drain();
      test_backpressure();
      test_random_mix(300, 60, 1'b0);
      test_random_mix(300, 45, 1'b1);
      test_no_idle();
      test_full_store();
      test_random_mix(250, 40, 1'b0);

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
